// File: design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low.
`define CLL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst_n is low.
`define CLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cll_pkg.sv
// Shared types and field widths for the cursor linked list engine.
package cll_pkg;

  localparam int IdW   = 32;
  localparam int KeyW  = 64;
  localparam int RecW  = 64;
  localparam int SlotW = 6;

  typedef enum logic [2:0] {
    FN_INIT       = 3'd0,
    FN_INS_FRONT  = 3'd1,
    FN_INS_END    = 3'd2,
    FN_INS_SORTED = 3'd3,
    FN_DEL_FRONT  = 3'd4,
    FN_DEL_END    = 3'd5,
    FN_DEL_ID     = 3'd6
  } cll_func_t;

  typedef enum logic [1:0] {
    ST_INIT    = 2'd0,
    ST_ADDED   = 2'd1,
    ST_DELETED = 2'd2,
    ST_FAILED  = 2'd3
  } cll_status_t;

  typedef struct packed {
    cll_func_t                func;
    logic signed [IdW-1:0]    entry_id;
    logic        [KeyW-1:0]   sort_key;
    logic        [RecW-1:0]   record_data;
  } cll_in_t;

  typedef struct packed {
    cll_status_t              status;
    logic        [SlotW-1:0]  slot;
  } cll_out_t;

endpackage

// File: design/cll_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module cll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/cursor_linked_list_engine.sv
// Linked list engine over a fixed slot pool, with free list and a single list head.
// Input channel (in_valid/in_stall/in_data) takes one operation per beat: init,
// insert front/end/sorted, delete front/end, or delete by id. Each beat gives exactly
// one result beat on out_valid/out_stall/out_data: a status and the slot touched.
// One operation is in flight at a time; in_stall is high from the accepting edge
// until the sequencer is back in idle.
// Insert front goes straight to slot allocation; an insert on a full pool, or a delete
// front or end on an empty list, goes straight to the result. The other inserts and
// deletes walk the list from the head over at most POOL_DEPTH records; a delete by id
// that finds nothing goes from the walk straight to the result.
// The walk reads one link per cycle from the link RAM, whose registered read sets
// the pace.
// Init rewrites every link entry, one per cycle.
// After reset the same link sweep runs with in_stall high and no result beat; the
// list is then empty and every slot free.
// A finished result sits in the output register until taken; while out_stall holds
// it, the next beat is still accepted and worked, and its result waits in the
// sequencer until the output register frees.
module cursor_linked_list_engine #(
  parameter int POOL_DEPTH = 64,
  parameter int DATA_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cll_pkg::cll_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cll_pkg::cll_out_t  out_data
);

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int LW = IW + 1;
  localparam int SW = cll_pkg::SlotW;
  localparam int RW = cll_pkg::IdW + cll_pkg::KeyW + DATA_WIDTH;
  localparam logic [LW-1:0] NIL  = LW'(POOL_DEPTH);
  localparam logic [IW-1:0] LAST = IW'(POOL_DEPTH - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SWEEP  = 8'b0000_0010,
    S_WALK   = 8'b0000_0100,
    S_ALLOC  = 8'b0000_1000,
    S_LINK   = 8'b0001_0000,
    S_UNLINK = 8'b0010_0000,
    S_FREE   = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  cll_pkg::cll_in_t  op_r, op_nxt;
  logic [LW-1:0]     x_r, x_nxt;
  logic [LW-1:0]     prev_r, prev_nxt;
  logic [LW-1:0]     nx_r, nx_nxt;
  logic [LW-1:0]     attach_r, attach_nxt;
  logic [LW-1:0]     t_r, t_nxt;
  logic [LW-1:0]     free_head_r, free_head_nxt;
  logic [LW-1:0]     list_head_r, list_head_nxt;
  logic [IW-1:0]     cnt_r, cnt_nxt;
  logic              found_r, found_nxt;
  logic              init_op_r, init_op_nxt;
  cll_pkg::cll_out_t res_r, res_nxt;
  cll_pkg::cll_out_t out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              lk_we;
  logic [IW-1:0]     lk_waddr;
  logic [LW-1:0]     lk_wdata;
  logic [IW-1:0]     lk_raddr;
  logic [LW-1:0]     lk_rdata;
  logic              rc_we;
  logic [IW-1:0]     rc_waddr;
  logic [RW-1:0]     rc_wdata;
  logic              rc_re;
  logic [IW-1:0]     rc_raddr;
  logic [RW-1:0]     rc_rdata;

  logic                      x_ok;
  logic                      hit;
  logic [RW-1:0]             new_rec;
  logic [cll_pkg::KeyW-1:0]  rd_key;
  logic [cll_pkg::IdW-1:0]   rd_id;

  function automatic logic [SW-1:0] slot_of(input logic [LW-1:0] v);
    return SW'(v);
  endfunction

  cll_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .re    (1'b1),
    .raddr (lk_raddr),
    .rdata (lk_rdata)
  );

  cll_ram #(.WIDTH(RW), .DEPTH(POOL_DEPTH)) u_rec_ram (
    .clk   (clk),
    .we    (rc_we),
    .waddr (rc_waddr),
    .wdata (rc_wdata),
    .re    (rc_re),
    .raddr (rc_raddr),
    .rdata (rc_rdata)
  );

  assign new_rec  = {op_r.entry_id, op_r.sort_key, op_r.record_data[DATA_WIDTH-1:0]};
  assign rd_key   = rc_rdata[DATA_WIDTH +: cll_pkg::KeyW];
  assign rd_id    = rc_rdata[DATA_WIDTH + cll_pkg::KeyW +: cll_pkg::IdW];
  assign x_ok     = x_r < NIL;
  assign in_stall = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Walk stop condition for the current record
  always_comb begin
    unique case (op_r.func)
      cll_pkg::FN_INS_END,
      cll_pkg::FN_DEL_END:    hit = !(lk_rdata < NIL);
      cll_pkg::FN_INS_SORTED: hit = rd_key >= op_r.sort_key;
      cll_pkg::FN_DEL_ID:     hit = rd_id == op_r.entry_id;
      default:                hit = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    prev_nxt      = prev_r;
    nx_nxt        = nx_r;
    attach_nxt    = attach_r;
    t_nxt         = t_r;
    free_head_nxt = free_head_r;
    list_head_nxt = list_head_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    init_op_nxt   = init_op_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    lk_we    = 1'b0;
    lk_waddr = x_r[IW-1:0];
    lk_wdata = NIL;
    lk_raddr = x_r[IW-1:0];
    rc_we    = 1'b0;
    rc_waddr = x_r[IW-1:0];
    rc_wdata = new_rec;
    rc_re    = 1'b0;
    rc_raddr = x_r[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = in_data;
          x_nxt          = list_head_r;
          prev_nxt       = NIL;
          lk_raddr       = list_head_r[IW-1:0];
          rc_raddr       = list_head_r[IW-1:0];
          rc_re          = 1'b1;
          res_nxt.status = cll_pkg::ST_FAILED;
          res_nxt.slot   = '0;
          state_nxt      = S_RESP;
          unique case (in_data.func)
            cll_pkg::FN_INIT: begin
              cnt_nxt       = '0;
              init_op_nxt   = 1'b1;
              free_head_nxt = '0;
              list_head_nxt = NIL;
              state_nxt     = S_SWEEP;
            end
            cll_pkg::FN_INS_FRONT: begin
              if (free_head_r < NIL) begin
                lk_raddr  = free_head_r[IW-1:0];
                state_nxt = S_ALLOC;
              end
            end
            cll_pkg::FN_INS_END,
            cll_pkg::FN_INS_SORTED: begin
              if (free_head_r < NIL) begin
                state_nxt = S_WALK;
              end
            end
            cll_pkg::FN_DEL_FRONT,
            cll_pkg::FN_DEL_END: begin
              if (list_head_r < NIL) begin
                state_nxt = S_WALK;
              end
            end
            cll_pkg::FN_DEL_ID: begin
              state_nxt = S_WALK;
            end
            default: ;
          endcase
        end
      end

      S_SWEEP: begin
        // Chain slot i to i + 1; the last slot gets the null marker
        lk_we    = 1'b1;
        lk_waddr = cnt_r;
        lk_wdata = {1'b0, cnt_r} + LW'(1);
        cnt_nxt  = cnt_r + IW'(1);
        if (cnt_r == LAST) begin
          init_op_nxt    = 1'b0;
          res_nxt.status = cll_pkg::ST_INIT;
          res_nxt.slot   = '0;
          state_nxt      = init_op_r ? S_RESP : S_IDLE;
        end
      end

      S_WALK: begin
        if (x_ok && !hit) begin
          // Advance one record; issue reads at the successor
          prev_nxt = x_r;
          x_nxt    = lk_rdata;
          lk_raddr = lk_rdata[IW-1:0];
          rc_raddr = lk_rdata[IW-1:0];
          rc_re    = 1'b1;
        end else begin
          nx_nxt = lk_rdata;
          if (op_r.func == cll_pkg::FN_INS_END || op_r.func == cll_pkg::FN_INS_SORTED) begin
            // Read the free-list successor; hold the record read data
            lk_raddr   = free_head_r[IW-1:0];
            found_nxt  = (op_r.func == cll_pkg::FN_INS_SORTED) && x_ok;
            attach_nxt = (op_r.func == cll_pkg::FN_INS_END) ? x_r : prev_r;
            state_nxt  = S_ALLOC;
          end else if (x_ok) begin
            state_nxt = S_UNLINK;
          end else begin
            res_nxt.status = cll_pkg::ST_FAILED;
            res_nxt.slot   = '0;
            state_nxt      = S_RESP;
          end
        end
      end

      S_ALLOC: begin
        t_nxt         = free_head_r;
        free_head_nxt = lk_rdata;
        lk_we         = 1'b1;
        lk_waddr      = free_head_r[IW-1:0];
        rc_we         = 1'b1;
        rc_waddr      = free_head_r[IW-1:0];
        if (op_r.func == cll_pkg::FN_INS_FRONT) begin
          lk_wdata       = list_head_r;
          list_head_nxt  = free_head_r;
          res_nxt.status = cll_pkg::ST_ADDED;
          res_nxt.slot   = slot_of(free_head_r);
          state_nxt      = S_RESP;
        end else if (found_r) begin
          // New slot takes over the found record and its successor
          lk_wdata  = nx_r;
          rc_wdata  = rc_rdata;
          state_nxt = S_LINK;
        end else begin
          lk_wdata  = NIL;
          state_nxt = S_LINK;
        end
      end

      S_LINK: begin
        res_nxt.status = cll_pkg::ST_ADDED;
        if (found_r) begin
          lk_we        = 1'b1;
          lk_waddr     = x_r[IW-1:0];
          lk_wdata     = t_r;
          rc_we        = 1'b1;
          rc_waddr     = x_r[IW-1:0];
          res_nxt.slot = slot_of(x_r);
        end else begin
          if (attach_r < NIL) begin
            lk_we    = 1'b1;
            lk_waddr = attach_r[IW-1:0];
            lk_wdata = t_r;
          end else begin
            list_head_nxt = t_r;
          end
          res_nxt.slot = slot_of(t_r);
        end
        state_nxt = S_RESP;
      end

      S_UNLINK: begin
        if (prev_r < NIL) begin
          lk_we    = 1'b1;
          lk_waddr = prev_r[IW-1:0];
          lk_wdata = nx_r;
        end else begin
          list_head_nxt = nx_r;
        end
        state_nxt = S_FREE;
      end

      S_FREE: begin
        lk_we          = 1'b1;
        lk_waddr       = x_r[IW-1:0];
        lk_wdata       = free_head_r;
        free_head_nxt  = x_r;
        res_nxt.status = cll_pkg::ST_DELETED;
        res_nxt.slot   = slot_of(x_r);
        state_nxt      = S_RESP;
      end

      S_RESP: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      cnt_r       <= '0;
      init_op_r   <= 1'b0;
      free_head_r <= '0;
      list_head_r <= NIL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      init_op_r   <= init_op_nxt;
      free_head_r <= free_head_nxt;
      list_head_r <= list_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    x_r      <= x_nxt;
    prev_r   <= prev_nxt;
    nx_r     <= nx_nxt;
    attach_r <= attach_nxt;
    t_r      <= t_nxt;
    found_r  <= found_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

endmodule

// File: design/cll_checker.sv
// Port-level checks for the cursor linked list engine, bound to the top level.
`include "assert_macros.svh"

module cll_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input cll_pkg::cll_out_t out_data
);

  // One operation at a time: an accepted beat closes the input until it is done
  `CLL_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second beat accepted while busy")

  // Init and failed results never name a slot
  `CLL_ASSERT_IMP(a_zero_slot, out_valid && (out_data.status == cll_pkg::ST_INIT || out_data.status == cll_pkg::ST_FAILED), out_data.slot == '0, "non-zero slot on init or failure")

  `CLL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat dropped or changed")

endmodule

bind cursor_linked_list_engine cll_checker u_cll_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/sv/cursor_linked_list_engine_tb.sv
// Self-checking testbench for the cursor linked list engine: list operations against a pool shadow.
module cursor_linked_list_engine_tb;
  import cll_pkg::*;

  localparam int POOL = 64;
  localparam logic [6:0] NIL = 7'(POOL);
  localparam int RAND_OPS = 1100;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 80;
  localparam logic signed [31:0] ID_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] ID_MIN = 32'sh8000_0000;
  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam cll_out_t PREDICTED = '{ST_FAILED, 6'd0};

  typedef struct {
    cll_in_t  beat;
    bit       typed;
    cll_out_t want;
  } plan_row_t;

  localparam int PLAN_ROWS = 21;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  cll_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cll_out_t out_data;

  // shadow of the pool
  logic [6:0]  lnk [POOL];
  logic [31:0] rec_id [POOL];
  logic [63:0] rec_key [POOL];
  logic [63:0] rec_data [POOL];
  logic [6:0]  free_top;
  logic [6:0]  head;

  cll_out_t  pending_results [$];
  int        ops_sent = 0;
  int        results_seen = 0;
  int        fails = 0;
  int        cycles = 0;
  int        burst_left = 0;
  plan_row_t plan [PLAN_ROWS];

  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit first_hold_done = 1'b0;
  bit second_hold_done = 1'b0;

  cursor_linked_list_engine i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  function automatic void clear_pool();
    for (int i = 0; i < POOL - 1; i++) lnk[i] = 7'(i + 1);
    lnk[POOL-1] = NIL;
    free_top = 7'd0;
    head = NIL;
  endfunction

  function automatic logic [6:0] grab_slot();
    logic [6:0] s;
    s = free_top;
    free_top = lnk[s];
    return s;
  endfunction

  function automatic void release_slot(input logic [6:0] s);
    lnk[s] = free_top;
    free_top = s;
  endfunction

  function automatic void store_rec(input logic [6:0] s, input cll_in_t b);
    rec_id[s] = b.entry_id;
    rec_key[s] = b.sort_key;
    rec_data[s] = b.record_data;
  endfunction

  function automatic logic [6:0] append_rec(input cll_in_t b);
    logic [6:0] s;
    logic [6:0] x;
    int n;
    s = grab_slot();
    store_rec(s, b);
    lnk[s] = NIL;
    if (head == NIL) begin
      head = s;
    end else begin
      x = head;
      n = 0;
      while (lnk[x] != NIL && n < POOL) begin
        x = lnk[x];
        n++;
      end
      lnk[x] = s;
    end
    return s;
  endfunction

  // Apply one operation to the shadow pool and return the result it should give.
  function automatic cll_out_t predict_list_op(input cll_in_t b);
    cll_out_t   r;
    logic [6:0] x;
    logic [6:0] prev;
    logic [6:0] t;
    int         n;
    r = '{ST_FAILED, 6'd0};
    n = 0;
    case (b.func)
      FN_INIT: begin
        clear_pool();
        r.status = ST_INIT;
      end
      FN_INS_FRONT: begin
        if (free_top != NIL) begin
          t = grab_slot();
          store_rec(t, b);
          lnk[t] = head;
          head = t;
          r = '{ST_ADDED, t[5:0]};
        end
      end
      FN_INS_END: begin
        if (free_top != NIL) begin
          t = append_rec(b);
          r = '{ST_ADDED, t[5:0]};
        end
      end
      FN_INS_SORTED: begin
        if (free_top != NIL) begin
          x = head;
          while (x != NIL && rec_key[x] < b.sort_key && n < POOL) begin
            x = lnk[x];
            n++;
          end
          if (x != NIL) begin
            // found record moves to the new slot behind it, new record takes its place
            t = grab_slot();
            rec_id[t] = rec_id[x];
            rec_key[t] = rec_key[x];
            rec_data[t] = rec_data[x];
            lnk[t] = lnk[x];
            lnk[x] = t;
            store_rec(x, b);
          end else begin
            x = append_rec(b);
          end
          r = '{ST_ADDED, x[5:0]};
        end
      end
      FN_DEL_FRONT: begin
        if (head != NIL) begin
          x = head;
          head = lnk[x];
          release_slot(x);
          r = '{ST_DELETED, x[5:0]};
        end
      end
      FN_DEL_END: begin
        if (head != NIL) begin
          x = head;
          prev = NIL;
          while (lnk[x] != NIL && n < POOL) begin
            prev = x;
            x = lnk[x];
            n++;
          end
          if (prev == NIL) head = NIL;
          else lnk[prev] = NIL;
          release_slot(x);
          r = '{ST_DELETED, x[5:0]};
        end
      end
      FN_DEL_ID: begin
        x = head;
        prev = NIL;
        while (x != NIL && rec_id[x] != b.entry_id && n < POOL) begin
          prev = x;
          x = lnk[x];
          n++;
        end
        if (x != NIL && rec_id[x] == b.entry_id) begin
          if (prev == NIL) head = lnk[x];
          else lnk[prev] = lnk[x];
          release_slot(x);
          r = '{ST_DELETED, x[5:0]};
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one beat, hold it until taken, then record what it should produce.
  task automatic offer_beat(input cll_in_t b, input bit typed, input cll_out_t want);
    cll_out_t p;
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    p = predict_list_op(b);
    pending_results.push_back(typed ? want : p);
    ops_sent++;
  endtask

  // Bursts of back-to-back beats separated by random gaps.
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen != ops_sent) @(posedge clk);
  endtask

  initial begin : stimulus
    cll_in_t    b;
    logic [6:0] x;
    int         phase;
    int         phase_left;
    int         ins_pct;
    int         roll;
    int         hops;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    phase = 0;
    phase_left = 0;
    clear_pool();
    plan = '{
      '{'{FN_DEL_FRONT,  32'sd0,     64'd0,     64'd0}, 1'b1, '{ST_FAILED, 6'd0}},
      '{'{FN_DEL_END,    32'sd0,     64'd0,     64'd0}, 1'b1, '{ST_FAILED, 6'd0}},
      '{'{FN_DEL_ID,     32'sd0,     64'd0,     64'd0}, 1'b1, '{ST_FAILED, 6'd0}},
      '{'{FN_INS_END,    ID_MAX,     ALL1,      ALL1},  1'b1, '{ST_ADDED, 6'd0}},
      '{'{FN_INS_FRONT,  ID_MIN,     64'd0,     64'd0}, 1'b1, '{ST_ADDED, 6'd1}},
      '{'{FN_INS_SORTED, 32'sd1,     64'd0,
          64'hA5A5_A5A5_A5A5_A5A5}, 1'b0, PREDICTED},
      '{'{FN_INS_SORTED, 32'sd2,     64'h8000_0000_0000_0000,
          64'h5A5A_5A5A_5A5A_5A5A}, 1'b0, PREDICTED},
      '{'{FN_INS_FRONT,  -32'sd1,    64'd3,     64'd1}, 1'b0, PREDICTED},
      '{'{FN_DEL_ID,     ID_MIN,     64'd0,     64'd0}, 1'b0, PREDICTED},
      '{'{FN_DEL_ID,     32'sd12345, 64'd0,     64'd0}, 1'b1, '{ST_FAILED, 6'd0}},
      '{'{FN_DEL_END,    32'sd0,     64'd0,     64'd0}, 1'b0, PREDICTED},
      '{'{FN_DEL_FRONT,  32'sd0,     64'd0,     64'd0}, 1'b0, PREDICTED},
      '{'{FN_INIT,       32'sd0,     64'd0,     64'd0}, 1'b1, '{ST_INIT, 6'd0}},
      '{'{FN_INS_SORTED, 32'sd5,     64'd5,     64'd7}, 1'b1, '{ST_ADDED, 6'd0}},
      '{'{FN_DEL_END,    32'sd0,     64'd0,     64'd0}, 1'b1, '{ST_DELETED, 6'd0}},
      '{'{FN_INS_END,    32'sd6,     64'd5,     64'd0}, 1'b1, '{ST_ADDED, 6'd0}},
      '{'{FN_INS_SORTED, 32'sd7,     64'd9,     64'd2}, 1'b0, PREDICTED},
      '{'{FN_INS_SORTED, 32'sd8,     64'd5,     64'd3}, 1'b0, PREDICTED},
      '{'{FN_DEL_ID,     32'sd7,     64'd0,     64'd0}, 1'b0, PREDICTED},
      '{'{FN_DEL_ID,     32'sd6,     64'd0,     64'd0}, 1'b0, PREDICTED},
      '{'{FN_INIT,       32'sd0,     64'd0,     64'd0}, 1'b1, '{ST_INIT, 6'd0}}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      pace();
      offer_beat(plan[r].beat, plan[r].typed, plan[r].want);
    end
    drain();

    for (int k = 0; k < RAND_OPS; k++) begin
      if (k == RAND_OPS / 2) drain();
      // fill-heavy, drain-heavy and balanced phases so the pool runs full and empty
      if (phase_left == 0) begin
        phase = $urandom_range(0, 2);
        phase_left = $urandom_range(60, 160);
      end
      phase_left--;
      ins_pct = (phase == 0) ? 90 : (phase == 1) ? 15 : 50;
      b.entry_id = $urandom_range(0, 1) ? 32'($urandom_range(0, 15)) : 32'($urandom);
      b.sort_key = $urandom_range(0, 1) ? 64'($urandom_range(0, 31)) : {$urandom, $urandom};
      b.record_data = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll == 0) begin
        b.func = FN_INIT;
      end else if (roll <= ins_pct) begin
        case ($urandom_range(0, 3))
          0: b.func = FN_INS_FRONT;
          1: b.func = FN_INS_END;
          default: b.func = FN_INS_SORTED;
        endcase
      end else begin
        case ($urandom_range(0, 3))
          0: b.func = FN_DEL_FRONT;
          1: b.func = FN_DEL_END;
          default: b.func = FN_DEL_ID;
        endcase
      end
      // mostly aim a delete by id at a record that is on the list
      if (b.func == FN_DEL_ID && head != NIL && $urandom_range(0, 3) != 0) begin
        x = head;
        hops = $urandom_range(0, POOL - 1);
        while (hops > 0 && lnk[x] != NIL) begin
          x = lnk[x];
          hops--;
        end
        b.entry_id = rec_id[x];
      end
      pace();
      offer_beat(b, 1'b0, PREDICTED);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      fails++;
    end
    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin : result_check
    cll_out_t w;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                 $time, out_data.status, out_data.slot);
        fails++;
      end else begin
        w = pending_results.pop_front();
        if (out_data.status !== w.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, w.status, out_data.status);
          fails++;
        end
        if (out_data.slot !== w.slot) begin
          $display("%0t: slot mismatch, expected %0d actual %0d",
                   $time, w.slot, out_data.slot);
          fails++;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // Receiver back-pressure: random modes, plus two long hold-offs to fill the block.
  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!first_hold_done && results_seen >= 250) begin
      first_hold_done = 1'b1;
      hold_left = 500;
      out_stall <= 1'b1;
    end else if (!second_hold_done && results_seen >= 700) begin
      second_hold_done = 1'b1;
      hold_left = 300;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run timed out after %0d cycles", $time, cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

endmodule

// File: sim.f
+incdir+design
design/cll_pkg.sv
design/cll_ram.sv
design/cursor_linked_list_engine.sv
design/cll_checker.sv
tb/sv/cursor_linked_list_engine_tb.sv
